### hdl/bnc_pkg.sv
// ----------------------------------------------------------------------------
// bnc_pkg
// Shared types, constants and helpers for the BGRA to NV12 converter.
// ----------------------------------------------------------------------------
package bnc_pkg;

	localparam int PIX_W   = 8;   // one color component
	localparam int PAIR_W  = 9;   // sum of two components
	localparam int QUAD_W  = 10;  // sum of four components
	localparam int CS_W    = 19;  // signed chroma accumulator
	localparam int LACC_W  = 16;  // luma accumulator
	localparam int CFG_W   = 13;  // configuration register width
	localparam int CFG_XW  = CFG_W + 1;
	localparam int REG_IDX_W = 1;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam logic [CFG_W-1:0] DEF_FRAME_WIDTH  = CFG_W'(1920);
	localparam logic [CFG_W-1:0] DEF_FRAME_HEIGHT = CFG_W'(1080);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// Luma: ((66 r + 129 g + 25 b + 128) >> 8) + 16
	localparam logic [LACC_W-1:0] Y_COEF_R = LACC_W'(66);
	localparam logic [LACC_W-1:0] Y_COEF_G = LACC_W'(129);
	localparam logic [LACC_W-1:0] Y_COEF_B = LACC_W'(25);
	localparam logic [LACC_W-1:0] Y_ROUND  = LACC_W'(128);
	localparam logic [PIX_W-1:0]  Y_OFFSET = PIX_W'(16);

	// Chroma over 2x2 sums, then floor shift by 10
	localparam logic signed [CS_W-1:0] U_COEF_B = CS_W'(112);
	localparam logic signed [CS_W-1:0] U_COEF_G = CS_W'(74);
	localparam logic signed [CS_W-1:0] U_COEF_R = CS_W'(38);
	localparam logic signed [CS_W-1:0] V_COEF_R = CS_W'(112);
	localparam logic signed [CS_W-1:0] V_COEF_G = CS_W'(94);
	localparam logic signed [CS_W-1:0] V_COEF_B = CS_W'(18);
	localparam logic signed [CS_W-1:0] C_ROUND  = CS_W'(512);
	localparam logic signed [CS_W-1:0] C_MID    = CS_W'(128);
	localparam logic signed [CS_W-1:0] C_MAX    = CS_W'(255);
	localparam int C_SHIFT = 10;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	// Line store word: {r:9, g:9, b:9}
	typedef struct packed {
		logic [PAIR_W-1:0] red;
		logic [PAIR_W-1:0] green;
		logic [PAIR_W-1:0] blue;
	} pair_t;

	typedef struct packed {
		logic chroma;
		logic eof;
	} pix_ctl_t;

	typedef struct packed {
		logic [PIX_W-1:0] luma;
		logic             chroma_valid;
		logic [PIX_W-1:0] chroma_u;
		logic [PIX_W-1:0] chroma_v;
		logic             end_of_frame;
	} result_t;

	function automatic logic [PIX_W-1:0] clip_byte(input logic signed [CS_W-1:0] v);
		logic [PIX_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > C_MAX) begin
			r = '1;
		end else begin
			r = v[PIX_W-1:0];
		end
		return r;
	endfunction

endpackage

### hdl/bnc_line_store.sv
// ----------------------------------------------------------------------------
// bnc_line_store
// Line memory of horizontal pair sums, one write and one registered read port.
// ----------------------------------------------------------------------------
module bnc_line_store #(
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  bnc_pkg::pair_t      wdata,
	input  logic                re,
	input  logic [ADDR_W-1:0]   raddr,
	output bnc_pkg::pair_t      rdata
);

	bnc_pkg::pair_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds until the next read, so a stalled consumer keeps it.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/bnc_datapath.sv
// ----------------------------------------------------------------------------
// bnc_datapath
// Three-stage color math: 2x2 sums and luma, chroma products, shift and clip.
// ----------------------------------------------------------------------------
module bnc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  bnc_pkg::pixel_t     in_pix,
	input  bnc_pkg::pair_t      in_pair,
	input  bnc_pkg::pix_ctl_t   in_ctl,
	input  bnc_pkg::pair_t      line_rdata,
	output logic                out_valid,
	output bnc_pkg::result_t    out_res
);

	logic                         v_s1, v_s2, v_s3;
	bnc_pkg::pixel_t              pix_s1;
	bnc_pkg::pair_t               pair_s1;
	bnc_pkg::pix_ctl_t            ctl_s1, ctl_s2, ctl_s3;
	logic [bnc_pkg::PIX_W-1:0]    luma_s2, luma_s3;
	logic [bnc_pkg::QUAD_W-1:0]   rs_s2, gs_s2, bs_s2;
	logic signed [bnc_pkg::CS_W-1:0] u_sum_s3, v_sum_s3;

	logic [bnc_pkg::LACC_W-1:0]   luma_acc;
	logic [bnc_pkg::PIX_W-1:0]    luma_calc;
	logic signed [bnc_pkg::CS_W-1:0] rs_x, gs_x, bs_x, u_calc, v_calc;
	logic signed [bnc_pkg::CS_W-1:0] u_fin, v_fin;

	// Maximum sum is 56228, so the luma byte stays within 16..235.
	assign luma_acc = bnc_pkg::Y_COEF_R * bnc_pkg::LACC_W'(pix_s1.red)
		+ bnc_pkg::Y_COEF_G * bnc_pkg::LACC_W'(pix_s1.green)
		+ bnc_pkg::Y_COEF_B * bnc_pkg::LACC_W'(pix_s1.blue)
		+ bnc_pkg::Y_ROUND;
	assign luma_calc = luma_acc[bnc_pkg::LACC_W-1 -: bnc_pkg::PIX_W] + bnc_pkg::Y_OFFSET;

	assign rs_x = signed'(bnc_pkg::CS_W'(rs_s2));
	assign gs_x = signed'(bnc_pkg::CS_W'(gs_s2));
	assign bs_x = signed'(bnc_pkg::CS_W'(bs_s2));

	assign u_calc = bnc_pkg::U_COEF_B * bs_x - bnc_pkg::U_COEF_G * gs_x
		- bnc_pkg::U_COEF_R * rs_x + bnc_pkg::C_ROUND;
	assign v_calc = bnc_pkg::V_COEF_R * rs_x - bnc_pkg::V_COEF_G * gs_x
		- bnc_pkg::V_COEF_B * bs_x + bnc_pkg::C_ROUND;

	assign u_fin = (u_sum_s3 >>> bnc_pkg::C_SHIFT) + bnc_pkg::C_MID;
	assign v_fin = (v_sum_s3 >>> bnc_pkg::C_SHIFT) + bnc_pkg::C_MID;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1   <= in_pix;
			pair_s1  <= in_pair;
			ctl_s1   <= in_ctl;

			ctl_s2   <= ctl_s1;
			luma_s2  <= luma_calc;
			rs_s2    <= bnc_pkg::QUAD_W'(pair_s1.red)   + bnc_pkg::QUAD_W'(line_rdata.red);
			gs_s2    <= bnc_pkg::QUAD_W'(pair_s1.green) + bnc_pkg::QUAD_W'(line_rdata.green);
			bs_s2    <= bnc_pkg::QUAD_W'(pair_s1.blue)  + bnc_pkg::QUAD_W'(line_rdata.blue);

			ctl_s3   <= ctl_s2;
			luma_s3  <= luma_s2;
			u_sum_s3 <= u_calc;
			v_sum_s3 <= v_calc;
		end
	end

	always_comb begin
		out_res.luma         = luma_s3;
		out_res.chroma_valid = ctl_s3.chroma;
		out_res.chroma_u     = ctl_s3.chroma ? bnc_pkg::clip_byte(u_fin) : '0;
		out_res.chroma_v     = ctl_s3.chroma ? bnc_pkg::clip_byte(v_fin) : '0;
		out_res.end_of_frame = ctl_s3.eof;
	end

	assign out_valid = v_s3;

	a_chroma_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s1 && ctl_s1.chroma) |=> (v_s2 && ctl_s2.chroma))
		else $error("chroma flag lost between stage 1 and stage 2");

endmodule

### hdl/bnc_out_skid.sv
// ----------------------------------------------------------------------------
// bnc_out_skid
// Output register with one spare entry; the pipeline stalls only when it fills.
// ----------------------------------------------------------------------------
module bnc_out_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bnc_pkg::result_t    push_data,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output bnc_pkg::result_t    out_data
);

	logic             out_valid_q, spare_valid_q;
	bnc_pkg::result_t out_q, spare_q;
	logic             pop;

	assign pop = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (spare_valid_q) begin
			// no push can arrive while the spare is full
			if (pop) begin
				spare_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				spare_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (spare_valid_q) begin
			if (pop) begin
				out_q <= spare_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				spare_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

	assign room      = !spare_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_spare_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q |-> out_valid_q)
		else $error("spare entry held without an output entry");

	a_spare_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(spare_valid_q && !out_ready) |=> spare_valid_q)
		else $error("spare entry dropped without a transfer");

endmodule

### hdl/bgra_to_nv12_color_converter.sv
// ----------------------------------------------------------------------------
// bgra_to_nv12_color_converter
// Raster BGR pixel stream to BT.601 limited-range luma and 4:2:0 chroma.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and returns one result per pixel.
// A result passes datapath stages s1, s2 and s3 into the output register
// and can leave from there on the next edge. Every result carries the luma
// byte; on odd rows at odd columns it also carries the chroma pair of the
// 2x2 block (tuser high), and tlast marks the last pixel of the frame.
// Pair sums of even rows wait in a line memory of MAX_WIDTH/2 entries with
// one write and one read port; a row's read of an entry always follows its
// write, so one pixel per clock holds with no interlock. s_axis_tready
// drops only when both output entries are full; there is no clearing pass
// after reset. Write frame_width and frame_height only while the stream is
// idle.
// ----------------------------------------------------------------------------
module bgra_to_nv12_color_converter #(
	parameter int MAX_WIDTH  = bnc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bnc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bnc_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [bnc_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [23:0]                       s_axis_tdata,  // blue, green, red
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [23:0]                       m_axis_tdata,  // luma, chroma_u, chroma_v
	output logic [0:0]                        m_axis_tuser,  // chroma_valid
	output logic                              m_axis_tlast   // end_of_frame
);

	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int RW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int LAW        = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic [bnc_pkg::CFG_W-1:0]  width_q, height_q;
	logic [CW-1:0]              col_cnt_q;
	logic [RW-1:0]              row_cnt_q;
	bnc_pkg::pixel_t            held_q;

	logic [bnc_pkg::CFG_XW-1:0] width_x, height_x, width_eff, height_eff;
	logic [bnc_pkg::CFG_XW-1:0] width_m1_x, height_m1_x;
	logic [CW-1:0]              width_m1, col;
	logic [RW-1:0]              height_m1;
	logic [CW:0]                col_x;
	logic [CW-1:0]              half;
	logic [LAW-1:0]             line_addr;
	logic                       last_col, last_row, accept, en;
	logic                       line_we, line_re;
	bnc_pkg::pixel_t            in_pix;
	bnc_pkg::pair_t             pair, line_rdata;
	bnc_pkg::pix_ctl_t          ctl;
	logic                       dp_valid;
	bnc_pkg::result_t           dp_res, out_res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bnc_pkg::DEF_FRAME_WIDTH;
			height_q <= bnc_pkg::DEF_FRAME_HEIGHT;
		end else if (cfg_we) begin
			if (cfg_index == bnc_pkg::REG_FRAME_WIDTH) begin
				width_q <= cfg_wdata;
			end
			if (cfg_index == bnc_pkg::REG_FRAME_HEIGHT) begin
				height_q <= cfg_wdata;
			end
		end
	end

	// Clamp the frame size to 1..MAX
	assign width_x  = bnc_pkg::CFG_XW'(width_q);
	assign height_x = bnc_pkg::CFG_XW'(height_q);

	always_comb begin
		priority if (width_q == '0) begin
			width_eff = bnc_pkg::CFG_XW'(1);
		end else if (width_x > bnc_pkg::CFG_XW'(MAX_WIDTH)) begin
			width_eff = bnc_pkg::CFG_XW'(MAX_WIDTH);
		end else begin
			width_eff = width_x;
		end
		priority if (height_q == '0) begin
			height_eff = bnc_pkg::CFG_XW'(1);
		end else if (height_x > bnc_pkg::CFG_XW'(MAX_HEIGHT)) begin
			height_eff = bnc_pkg::CFG_XW'(MAX_HEIGHT);
		end else begin
			height_eff = height_x;
		end
	end

	assign width_m1_x  = width_eff - bnc_pkg::CFG_XW'(1);
	assign height_m1_x = height_eff - bnc_pkg::CFG_XW'(1);
	assign width_m1    = width_m1_x[CW-1:0];
	assign height_m1   = height_m1_x[RW-1:0];

	// Raster position; a count past the last column or row ends it
	assign last_col = col_cnt_q >= width_m1;
	assign last_row = row_cnt_q >= height_m1;
	assign col      = last_col ? width_m1 : col_cnt_q;

	assign en            = s_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_pix.blue   = s_axis_tdata[7:0];
	assign in_pix.green  = s_axis_tdata[15:8];
	assign in_pix.red    = s_axis_tdata[23:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			held_q    <= '0;
		end else if (accept) begin
			if (!col[0]) begin
				held_q <= in_pix;
			end
			if (last_col) begin
				col_cnt_q <= '0;
				row_cnt_q <= last_row ? '0 : row_cnt_q + RW'(1);
			end else begin
				col_cnt_q <= col_cnt_q + CW'(1);
			end
		end
	end

	// Horizontal pair sum with the held even-column pixel
	assign pair.blue  = bnc_pkg::PAIR_W'(in_pix.blue)  + bnc_pkg::PAIR_W'(held_q.blue);
	assign pair.green = bnc_pkg::PAIR_W'(in_pix.green) + bnc_pkg::PAIR_W'(held_q.green);
	assign pair.red   = bnc_pkg::PAIR_W'(in_pix.red)   + bnc_pkg::PAIR_W'(held_q.red);

	// Line address is col/2, wrapping at the line depth
	assign col_x     = {1'b0, col};
	assign half      = col_x[CW:1];
	assign line_addr = (half == CW'(LINE_DEPTH)) ? '0 : half[LAW-1:0];

	assign line_we = accept && col[0] && !row_cnt_q[0];
	assign line_re = accept && col[0] && row_cnt_q[0];

	assign ctl.chroma = col[0] && row_cnt_q[0];
	assign ctl.eof    = last_col && last_row;

	bnc_line_store #(
		.DEPTH  (LINE_DEPTH),
		.ADDR_W (LAW)
	) u_line (
		.clk   (clk),
		.we    (line_we),
		.waddr (line_addr),
		.wdata (pair),
		.re    (line_re),
		.raddr (line_addr),
		.rdata (line_rdata)
	);

	bnc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (accept),
		.in_pix     (in_pix),
		.in_pair    (pair),
		.in_ctl     (ctl),
		.line_rdata (line_rdata),
		.out_valid  (dp_valid),
		.out_res    (dp_res)
	);

	bnc_out_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (dp_valid && en),
		.push_data (dp_res),
		.room      (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tdata = {out_res.chroma_v, out_res.chroma_u, out_res.luma};
	assign m_axis_tuser = out_res.chroma_valid;
	assign m_axis_tlast = out_res.end_of_frame;

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_col && last_row) |=> (col_cnt_q == '0 && row_cnt_q == '0))
		else $error("raster counters not cleared after the last pixel");

endmodule

### test/tb_bgra_to_nv12_color_converter.sv
// ----------------------------------------------------------------------------
// tb_bgra_to_nv12_color_converter
// Self-checking bench for the BGR to NV12 converter. A queue-fed driver
// streams pixels with random gaps. The bench recomputes luma, 2x2 chroma and
// frame end per accepted pixel, against its own copy of the line memory and
// of the counters. A monitor compares each result transfer under random
// backpressure, including one long hold that stalls the input.
// ----------------------------------------------------------------------------
module tb_bgra_to_nv12_color_converter;
	import bnc_pkg::*;

	localparam int MAX_W               = DEF_MAX_WIDTH;
	localparam int MAX_H               = DEF_MAX_HEIGHT;
	localparam int LINE_ENTRIES        = MAX_W / 2;
	localparam int RANDOM_PIXELS       = 1200;
	localparam int CYCLE_LIMIT         = 2000000;
	localparam int BACKPRESSURE_AT     = 80;
	localparam int BACKPRESSURE_QUEUED = 32;
	localparam int BACKPRESSURE_CYCLES = 400;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 cfg_we        = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index     = '0;
	logic [CFG_W-1:0]     cfg_wdata     = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata  = '0;  // blue, green, red
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [23:0]          m_axis_tdata;        // luma, chroma_u, chroma_v
	logic [0:0]           m_axis_tuser;        // chroma_valid
	logic                 m_axis_tlast;

	bgra_to_nv12_color_converter u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// converter state as the bench sees it
	logic [CFG_W-1:0] width_reg  = DEF_FRAME_WIDTH;
	logic [CFG_W-1:0] height_reg = DEF_FRAME_HEIGHT;
	pair_t            pair_line [LINE_ENTRIES];
	bit               line_loaded [LINE_ENTRIES];
	pixel_t           held_px = '0;
	int unsigned      col_pos = 0;
	int unsigned      row_pos = 0;

	pixel_t      pixel_q [$];
	result_t     expected_q [$];
	int unsigned cycle_count = 0;
	int unsigned mismatches  = 0;

	function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
		int unsigned d;
		d = v;
		if (d == 0)
			d = 1;
		if (d > lim)
			d = lim;
		return d;
	endfunction

	function automatic logic [7:0] sat_byte(input int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	task automatic convert_pixel(input pixel_t px);
		int unsigned w, h, col, pb, pg, pr, idx;
		int          bs, gs, rs;
		bit          last_col, last_row;
		result_t     res;
		w        = eff_dim(width_reg, MAX_W);
		h        = eff_dim(height_reg, MAX_H);
		last_col = col_pos >= w - 1;
		last_row = row_pos >= h - 1;
		col      = last_col ? w - 1 : col_pos;
		res      = '0;
		res.luma = sat_byte(((66 * px.red + 129 * px.green + 25 * px.blue + 128) >> 8) + 16);
		if (col[0] == 1'b0) begin
			held_px = px;
		end else begin
			pb  = px.blue + held_px.blue;
			pg  = px.green + held_px.green;
			pr  = px.red + held_px.red;
			idx = col >> 1;
			if (row_pos[0] == 1'b0) begin
				pair_line[idx]   = '{red: pr[8:0], green: pg[8:0], blue: pb[8:0]};
				line_loaded[idx] = 1'b1;
			end else begin
				bs = pb + pair_line[idx].blue;
				gs = pg + pair_line[idx].green;
				rs = pr + pair_line[idx].red;
				res.chroma_valid = 1'b1;
				res.chroma_u = sat_byte(128 + ((112 * bs - 74 * gs - 38 * rs + 512) >>> 10));
				res.chroma_v = sat_byte(128 + ((112 * rs - 94 * gs - 18 * bs + 512) >>> 10));
			end
		end
		if (last_col) begin
			col_pos = 0;
			if (last_row) begin
				row_pos = 0;
				res.end_of_frame = 1'b1;
			end else begin
				row_pos = row_pos + 1;
			end
		end else begin
			col_pos = col_pos + 1;
		end
		expected_q.push_back(res);
	endtask

	function automatic int unsigned pixels_to_frame_end();
		int unsigned w, h, r, c;
		w = eff_dim(width_reg, MAX_W);
		h = eff_dim(height_reg, MAX_H);
		r = (row_pos >= h - 1) ? h - 1 : row_pos;
		c = (col_pos >= w - 1) ? w - 1 : col_pos;
		return (h - 1 - r) * w + (w - c);
	endfunction

	// An odd row must never read a line entry that no even row has filled.
	function automatic bit width_fits_line(input logic [CFG_W-1:0] v);
		int unsigned w;
		w = eff_dim(v, MAX_W);
		if (row_pos[0] == 1'b0)
			return 1'b1;
		for (int unsigned c = 1; c < w; c += 2)
			if (!line_loaded[c >> 1])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned k;
		// every fourth window of the cycle count runs without idling
		if ((cycle_count / 512) % 4 == 0)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 70)
			return 0;
		if (k < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic pixel_t pix(input logic [7:0] r, g, b);
		pixel_t p;
		p.red   = r;
		p.green = g;
		p.blue  = b;
		return p;
	endfunction

	function automatic logic [7:0] rand_level();
		int unsigned k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return 8'h00;
		if (k == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	task automatic queue_random(input int unsigned n);
		repeat (n)
			pixel_q.push_back(pix(rand_level(), rand_level(), rand_level()));
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			width_reg = value;
		else
			height_reg = value;
	endtask

	task automatic wait_idle();
		while (pixel_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// pixel driver
	int unsigned send_gap = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				convert_pixel(pixel_t'(s_axis_tdata));
				send_gap = pick_gap();
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					send_gap = send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pixel_q.size() != 0) begin
					s_axis_tdata  <= pixel_q.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result sink: random stalls plus one long hold while pixels keep coming
	int unsigned sink_stall    = 0;
	int unsigned hold_cycles   = 0;
	int unsigned results_taken = 0;
	bit          hold_done     = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				results_taken = results_taken + 1;
			if (hold_cycles != 0) begin
				hold_cycles = hold_cycles - 1;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && results_taken >= BACKPRESSURE_AT
					&& pixel_q.size() >= BACKPRESSURE_QUEUED) begin
				hold_done   = 1'b1;
				hold_cycles = BACKPRESSURE_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (sink_stall != 0) begin
				sink_stall = sink_stall - 1;
				m_axis_tready <= 1'b0;
			end else begin
				sink_stall = pick_gap();
				m_axis_tready <= (sink_stall == 0);
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_q.size() == 0) begin
				$error("result transfer with nothing pending: tdata %h tuser %b tlast %b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				check_field("luma", want.luma, m_axis_tdata[7:0]);
				check_field("chroma_u", want.chroma_u, m_axis_tdata[15:8]);
				check_field("chroma_v", want.chroma_v, m_axis_tdata[23:16]);
				check_field("chroma_valid", want.chroma_valid, m_axis_tuser[0]);
				check_field("end_of_frame", want.end_of_frame, m_axis_tlast);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_bgra_to_nv12_color_converter: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned random_sent, w_new, h_new, n, k, frame_px;
		random_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// 4x2 frame: black, white, then a pure blue block for the top of U
		write_reg(REG_FRAME_WIDTH, 4);
		write_reg(REG_FRAME_HEIGHT, 2);
		pixel_q.push_back(pix(8'h00, 8'h00, 8'h00));
		pixel_q.push_back(pix(8'hFF, 8'hFF, 8'hFF));
		pixel_q.push_back(pix(8'h00, 8'h00, 8'hFF));
		pixel_q.push_back(pix(8'h00, 8'h00, 8'hFF));
		pixel_q.push_back(pix(8'h00, 8'h00, 8'h00));
		pixel_q.push_back(pix(8'hFF, 8'hFF, 8'hFF));
		pixel_q.push_back(pix(8'h00, 8'h00, 8'hFF));
		pixel_q.push_back(pix(8'h00, 8'h00, 8'hFF));
		wait_idle();

		// 2x2 frame of green and red
		write_reg(REG_FRAME_WIDTH, 2);
		pixel_q.push_back(pix(8'h00, 8'hFF, 8'h00));
		pixel_q.push_back(pix(8'hFF, 8'h00, 8'h00));
		pixel_q.push_back(pix(8'h00, 8'hFF, 8'h00));
		pixel_q.push_back(pix(8'hFF, 8'h00, 8'h00));
		wait_idle();

		// odd width and odd height: last column and last row get luma only
		write_reg(REG_FRAME_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 3);
		pixel_q.push_back(pix(8'hFF, 8'h00, 8'h00));
		pixel_q.push_back(pix(8'hFF, 8'hFF, 8'h00));
		pixel_q.push_back(pix(8'h00, 8'hFF, 8'hFF));
		pixel_q.push_back(pix(8'hFF, 8'h00, 8'h00));
		pixel_q.push_back(pix(8'hFF, 8'hFF, 8'h00));
		pixel_q.push_back(pix(8'h80, 8'h7F, 8'h01));
		pixel_q.push_back(pix(8'h00, 8'h00, 8'hFF));
		pixel_q.push_back(pix(8'hFF, 8'hFF, 8'hFF));
		pixel_q.push_back(pix(8'h55, 8'hAA, 8'h55));
		wait_idle();

		// zero sizes act as one: every pixel is a whole frame
		write_reg(REG_FRAME_WIDTH, 0);
		write_reg(REG_FRAME_HEIGHT, 0);
		pixel_q.push_back(pix(8'hFF, 8'hFF, 8'hFF));
		pixel_q.push_back(pix(8'h00, 8'h00, 8'h00));
		wait_idle();

		// oversize width clamps to the line length; a long run into one row
		// that the long output hold backs up against
		write_reg(REG_FRAME_WIDTH, 8191);
		write_reg(REG_FRAME_HEIGHT, 1);
		queue_random(200);
		wait_idle();

		// tall frame, then shrink the height mid-frame to end it early
		write_reg(REG_FRAME_WIDTH, 2);
		write_reg(REG_FRAME_HEIGHT, 4096);
		queue_random(40);
		wait_idle();
		write_reg(REG_FRAME_HEIGHT, 8191);
		queue_random(6);
		wait_idle();
		write_reg(REG_FRAME_HEIGHT, 1);
		queue_random(pixels_to_frame_end());
		wait_idle();

		while (random_sent < RANDOM_PIXELS) begin
			k = $urandom_range(0, 99);
			if (k < 3)
				w_new = 0;
			else if (k < 13)
				w_new = 2;
			else if (k < 85)
				w_new = $urandom_range(3, 16);
			else
				w_new = $urandom_range(17, 64);
			h_new = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
			if (width_fits_line(CFG_W'(w_new)))
				write_reg(REG_FRAME_WIDTH, CFG_W'(w_new));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_FRAME_HEIGHT, CFG_W'(h_new));
			frame_px = eff_dim(width_reg, MAX_W) * eff_dim(height_reg, MAX_H);
			// mostly run to a frame boundary; sometimes stop mid-frame
			if ($urandom_range(0, 3) != 0)
				n = pixels_to_frame_end() + $urandom_range(0, 1) * frame_px;
			else
				n = $urandom_range(1, 2 * frame_px);
			queue_random(n);
			random_sent += n;
			wait_idle();
		end

		if (mismatches == 0 && expected_q.size() == 0)
			$display("tb_bgra_to_nv12_color_converter: PASS");
		else
			$display("tb_bgra_to_nv12_color_converter: FAIL");
		$finish;
	end

endmodule
